/* design/pmrf_pkg.sv */
// Shared constants and types for the point multi-range filter.
`timescale 1ns / 1ps

package pmrf_pkg;

   // Width of every dimension field on the channels
   localparam int FIELD_WIDTH     = 32;
   // Number of dimension fields carried by one transaction
   localparam int MAX_DIMS        = 4;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;
   localparam int ACTIVE_WIDTH    = 3;
   localparam int UPPER_BOUND_LSB = 32;

   // Per-range flag layout
   localparam int FLAGS_PER_RANGE = 5;
   localparam int FLAG_INCL_LO    = 0;
   localparam int FLAG_INCL_HI    = 1;
   localparam int FLAG_NEGATE     = 2;
   localparam int FLAG_SEL_LSB    = 3;
   localparam int DIM_SEL_WIDTH   = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ACTIVE_RANGES = 3'd0,
      CSR_RANGE0_BOUNDS = 3'd1,
      CSR_RANGE1_BOUNDS = 3'd2,
      CSR_RANGE2_BOUNDS = 3'd3,
      CSR_RANGE3_BOUNDS = 3'd4,
      CSR_RANGE_FLAGS   = 3'd5
   } csr_index_type;

   typedef logic signed [FIELD_WIDTH-1:0] field_type;

endpackage

/* design/pmrf_req_if.sv */
// Point request channel: valid/ready handshake with four dimension values.
`timescale 1ns / 1ps

interface pmrf_req_if import pmrf_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type dim_value0;
   field_type dim_value1;
   field_type dim_value2;
   field_type dim_value3;

   modport source (output valid, dim_value0, dim_value1, dim_value2, dim_value3,
                   input  ready);
   modport sink   (input  valid, dim_value0, dim_value1, dim_value2, dim_value3,
                   output ready);
endinterface

/* design/pmrf_rsp_if.sv */
// Kept-point response channel: valid/ready handshake with four dimension values.
`timescale 1ns / 1ps

interface pmrf_rsp_if import pmrf_pkg::*; ();
   logic      valid;
   logic      ready;
   field_type kept_value0;
   field_type kept_value1;
   field_type kept_value2;
   field_type kept_value3;

   modport source (output valid, kept_value0, kept_value1, kept_value2, kept_value3,
                   input  ready);
   modport sink   (input  valid, kept_value0, kept_value1, kept_value2, kept_value3,
                   output ready);
endinterface

/* design/point_multi_range_filter.sv */
// Top level of the point multi-range filter: config registers, range tests, output stage.
`timescale 1ns / 1ps
//
// Streams points in on req_if and forwards on rsp_if only those that pass
// the configured range tests; a failing point is dropped and produces no
// rsp transaction. Up to NUM_RANGES range tests are set through the csr_
// write port (csr_we, csr_index, csr_wdata); write it only while no point
// is in flight.
//
// A point taken from req_if passes two register stages, the input register
// and then the output register, before it is presented on rsp_if.
// Throughput: one point per cycle while rsp_if is not stalled; the range
// tests are parallel compares between the two stages.
//
// Reset (synchronous, active high) empties both stages, sets active_ranges
// to 1 and clears all bounds and flags.
// When the receiver stalls, the output register holds its point and the
// input register still fills once; req_if.ready then drops until rsp_if
// moves again. A point that fails can leave the input register at any time.
//
module point_multi_range_filter import pmrf_pkg::*; #(
   parameter int NUM_DIMS    = 4,
   parameter int NUM_RANGES  = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   pmrf_req_if.sink                   req_if,
   pmrf_rsp_if.source                 rsp_if
);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [FLAGS_PER_RANGE-1:0]    flags_type;

   // Configuration registers
   logic [ACTIVE_WIDTH-1:0] active_ranges_ff, active_ranges_in;
   value_type               lo_bound_ff [NUM_RANGES];
   value_type               lo_bound_in [NUM_RANGES];
   value_type               hi_bound_ff [NUM_RANGES];
   value_type               hi_bound_in [NUM_RANGES];
   flags_type               flags_ff    [NUM_RANGES];
   flags_type               flags_in    [NUM_RANGES];

   // Input stage
   logic      s1_valid_ff, s1_valid_in;
   value_type s1_value_ff [NUM_DIMS];
   value_type s1_value_in [NUM_DIMS];

   // Output stage
   logic      out_valid_ff, out_valid_in;
   value_type out_value_ff [NUM_DIMS];
   value_type out_value_in [NUM_DIMS];

   field_type req_field [MAX_DIMS];
   field_type rsp_field [MAX_DIMS];

   logic [DIM_SEL_WIDTH-1:0] sel_raw  [NUM_RANGES];
   logic [DIM_SEL_WIDTH-1:0] sel_eff  [NUM_RANGES];
   value_type                sel_value[NUM_RANGES];
   logic [NUM_RANGES-1:0]    range_on;
   logic [NUM_RANGES-1:0]    range_pass;
   logic                     lo_fail, hi_fail, fail;
   logic [NUM_DIMS-1:0]      dim_used, dim_passed;
   logic                     keep;
   logic                     out_open, s1_move, req_take;

   assign req_field[0] = req_if.dim_value0;
   assign req_field[1] = req_if.dim_value1;
   assign req_field[2] = req_if.dim_value2;
   assign req_field[3] = req_if.dim_value3;

   // ---------------------------------------------------------------- config
   always_comb begin
      active_ranges_in = active_ranges_ff;
      lo_bound_in      = lo_bound_ff;
      hi_bound_in      = hi_bound_ff;
      flags_in         = flags_ff;
      if (csr_we) begin
         if (csr_index == CSR_ACTIVE_RANGES) begin
            active_ranges_in = csr_wdata[ACTIVE_WIDTH-1:0];
         end
         for (int r = 0; r < NUM_RANGES; r++) begin
            if (csr_index == CSR_INDEX_WIDTH'(int'(CSR_RANGE0_BOUNDS) + r)) begin
               lo_bound_in[r] = csr_wdata[VALUE_WIDTH-1:0];
               hi_bound_in[r] = csr_wdata[UPPER_BOUND_LSB +: VALUE_WIDTH];
            end
            if (csr_index == CSR_RANGE_FLAGS) begin
               flags_in[r] = csr_wdata[FLAGS_PER_RANGE*r +: FLAGS_PER_RANGE];
            end
         end
      end
   end

   // ----------------------------------------------------------- range tests
   always_comb begin
      range_on   = '0;
      range_pass = '0;
      dim_used   = '0;
      dim_passed = '0;
      lo_fail    = 1'b0;
      hi_fail    = 1'b0;
      fail       = 1'b0;
      for (int r = 0; r < NUM_RANGES; r++) begin
         // a count of zero still enables range zero; counts past the end saturate
         range_on[r] = (r == 0) || (active_ranges_ff > ACTIVE_WIDTH'(r));
         sel_raw[r]  = flags_ff[r][FLAG_SEL_LSB +: DIM_SEL_WIDTH];
         sel_eff[r]  = (int'(sel_raw[r]) >= NUM_DIMS) ? DIM_SEL_WIDTH'(NUM_DIMS - 1)
                                                      : sel_raw[r];
         sel_value[r] = '0;
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (sel_eff[r] == DIM_SEL_WIDTH'(d)) begin
               sel_value[r] = s1_value_ff[d];
            end
         end
         lo_fail = flags_ff[r][FLAG_INCL_LO] ? (sel_value[r] <  lo_bound_ff[r])
                                             : (sel_value[r] <= lo_bound_ff[r]);
         hi_fail = flags_ff[r][FLAG_INCL_HI] ? (sel_value[r] >  hi_bound_ff[r])
                                             : (sel_value[r] >= hi_bound_ff[r]);
         fail    = (lo_fail || hi_fail) ^ flags_ff[r][FLAG_NEGATE];
         range_pass[r] = !fail;
         for (int d = 0; d < NUM_DIMS; d++) begin
            if (range_on[r] && sel_eff[r] == DIM_SEL_WIDTH'(d)) begin
               dim_used[d]   = 1'b1;
               dim_passed[d] = dim_passed[d] | range_pass[r];
            end
         end
      end
      // OR within a dimension, AND across the dimensions in use
      keep = &(~dim_used | dim_passed);
   end

   // ------------------------------------------------------------- handshake
   assign out_open = !out_valid_ff || rsp_if.ready;
   // a dropped point leaves regardless of the output stage
   assign s1_move  = s1_valid_ff && (out_open || !keep);
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign req_take = req_if.valid && req_if.ready;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_value_in  = s1_value_ff;
      out_valid_in = out_valid_ff;
      out_value_in = out_value_ff;
      if (out_valid_ff && rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
      if (s1_move && keep) begin
         out_valid_in = 1'b1;
         out_value_in = s1_value_ff;
      end
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
         for (int d = 0; d < NUM_DIMS; d++) begin
            s1_value_in[d] = req_field[d][VALUE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ranges_ff <= ACTIVE_WIDTH'(1);
         for (int r = 0; r < NUM_RANGES; r++) begin
            lo_bound_ff[r] <= '0;
            hi_bound_ff[r] <= '0;
            flags_ff[r]    <= '0;
         end
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ranges_ff <= active_ranges_in;
         lo_bound_ff      <= lo_bound_in;
         hi_bound_ff      <= hi_bound_in;
         flags_ff         <= flags_in;
         s1_valid_ff      <= s1_valid_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // payload registers need no reset
   always_ff @(posedge clock) begin
      s1_value_ff  <= s1_value_in;
      out_value_ff <= out_value_in;
   end

   // ---------------------------------------------------------------- output
   always_comb begin
      for (int d = 0; d < MAX_DIMS; d++) begin
         rsp_field[d] = '0;
      end
      for (int d = 0; d < NUM_DIMS; d++) begin
         rsp_field[d] = FIELD_WIDTH'($unsigned(out_value_ff[d]));
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.kept_value0 = rsp_field[0];
   assign rsp_if.kept_value1 = rsp_field[1];
   assign rsp_if.kept_value2 = rsp_field[2];
   assign rsp_if.kept_value3 = rsp_field[3];

endmodule
